// ===== rtl/imubtr_pkg.sv =====
// ----------------------------------------------------------------------------
// imubtr_pkg : shared types and constants for the IMU correction block
// Register map codes, reset values of the rotation rows and lane unpacking.
// ----------------------------------------------------------------------------
package imubtr_pkg;

    localparam int FIELD_W   = 16;
    localparam int PACKED_W  = 48;
    localparam int CFG_DW    = 64;
    localparam int CFG_AW    = 6;
    localparam int AXES      = 3;
    localparam int SENSORS   = 2;
    localparam int CHANNELS  = AXES * SENSORS;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_ACC_OFFSET = 3'd0,
        REG_GYR_OFFSET = 3'd1,
        REG_ROW_FWD    = 3'd2,
        REG_ROW_LEFT   = 3'd3,
        REG_ROW_UP     = 3'd4,
        REG_REF_TEMP   = 3'd5,
        REG_ACC_SLOPE  = 3'd6,
        REG_GYR_SLOPE  = 3'd7
    } t_reg_idx;

    // identity matrix, 1.0 in Q2.14 on the diagonal
    localparam logic [PACKED_W-1:0] ROW_FWD_RST  = 48'h0000_0000_4000;
    localparam logic [PACKED_W-1:0] ROW_LEFT_RST = 48'h0000_4000_0000;
    localparam logic [PACKED_W-1:0] ROW_UP_RST   = 48'h4000_0000_0000;

    function automatic logic signed [FIELD_W-1:0] f_lane(
        input logic [PACKED_W-1:0] p,
        input logic [1:0]          k
    );
        logic signed [FIELD_W-1:0] v;
        case (k)
            2'd0:    v = p[15:0];
            2'd1:    v = p[31:16];
            2'd2:    v = p[47:32];
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/imu_bias_temp_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// imu_bias_temp_rotate_unit : IMU bias/temperature correction and rotation
// Subtracts bias and a temperature term from each axis, rotates both vectors
// into the vehicle frame, truncates toward zero and saturates to int16.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------
//  sample in | in        | i_valid / o_stall  | six raw axes, raw temperature
//  sample out| out       | o_valid / i_stall  | accel fwd/left/up, roll/pitch/yaw
//  config    | in/out    | APB psel..pready   | paddr[5:3] selects the register
//
//  Six register stages (difference, slope multiply, correction and clamp,
//  matrix products, row sums, shift and saturate) take one beat per cycle
//  while i_stall is low. Each stage loads whenever it is empty or the stage
//  after it moves, so bubbles close up under a downstream stall.
//  Synchronous active-low reset clears the stage valids and puts the
//  registers to their reset values; stage data is not reset.
// ----------------------------------------------------------------------------
module imu_bias_temp_rotate_unit #(
    parameter int MATRIX_FRAC_BITS = 14,
    parameter int SLOPE_FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample in
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_accel_x_raw,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_accel_y_raw,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_accel_z_raw,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_gyro_x_raw,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_gyro_y_raw,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_gyro_z_raw,
    input  logic signed [imubtr_pkg::FIELD_W-1:0] i_temperature_raw,
    // sample out
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [imubtr_pkg::FIELD_W-1:0] o_accel_forward,
    output logic signed [imubtr_pkg::FIELD_W-1:0] o_accel_left,
    output logic signed [imubtr_pkg::FIELD_W-1:0] o_accel_up,
    output logic signed [imubtr_pkg::FIELD_W-1:0] o_rate_roll,
    output logic signed [imubtr_pkg::FIELD_W-1:0] o_rate_pitch,
    output logic signed [imubtr_pkg::FIELD_W-1:0] o_rate_yaw,
    // config
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [imubtr_pkg::CFG_AW-1:0]        paddr,
    input  logic [imubtr_pkg::CFG_DW-1:0]        pwdata,
    output logic [imubtr_pkg::CFG_DW-1:0]        prdata,
    output logic                                 pready
);
    import imubtr_pkg::*;

    localparam int NSTG = 6;
    localparam int DW   = FIELD_W + 1;                       // raw - bias, dT
    localparam int TW   = 32 + DW;                           // slope * dT
    localparam int PW   = ((DW + SLOPE_FRAC_BITS > TW) ? DW + SLOPE_FRAC_BITS : TW) + 1;
    localparam int CW   = 21 + SLOPE_FRAC_BITS;              // clamped component
    localparam int PRW  = FIELD_W + CW;                      // one matrix product
    localparam int SW   = PRW + 2;                           // row sum
    localparam int SH   = SLOPE_FRAC_BITS + MATRIX_FRAC_BITS;

    localparam logic signed [PW-1:0] CORR_HI =
        $signed({{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [PW-1:0] CORR_LO =
        $signed({{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}});

    // ---------------- configuration registers ----------------
    logic [PACKED_W-1:0]      r_acc_offset, r_gyr_offset;
    logic [PACKED_W-1:0]      r_row_fwd, r_row_left, r_row_up;
    logic signed [15:0]       r_ref_temp;
    logic signed [31:0]       r_acc_slope, r_gyr_slope;
    logic                     w_cfg_wr;
    t_reg_idx                 w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_offset <= '0;
            r_gyr_offset <= '0;
            r_row_fwd    <= ROW_FWD_RST;
            r_row_left   <= ROW_LEFT_RST;
            r_row_up     <= ROW_UP_RST;
            r_ref_temp   <= '0;
            r_acc_slope  <= '0;
            r_gyr_slope  <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ACC_OFFSET: r_acc_offset <= pwdata[PACKED_W-1:0];
                REG_GYR_OFFSET: r_gyr_offset <= pwdata[PACKED_W-1:0];
                REG_ROW_FWD:    r_row_fwd    <= pwdata[PACKED_W-1:0];
                REG_ROW_LEFT:   r_row_left   <= pwdata[PACKED_W-1:0];
                REG_ROW_UP:     r_row_up     <= pwdata[PACKED_W-1:0];
                REG_REF_TEMP:   r_ref_temp   <= pwdata[15:0];
                REG_ACC_SLOPE:  r_acc_slope  <= pwdata[31:0];
                REG_GYR_SLOPE:  r_gyr_slope  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ACC_OFFSET: prdata = CFG_DW'(r_acc_offset);
            REG_GYR_OFFSET: prdata = CFG_DW'(r_gyr_offset);
            REG_ROW_FWD:    prdata = CFG_DW'(r_row_fwd);
            REG_ROW_LEFT:   prdata = CFG_DW'(r_row_left);
            REG_ROW_UP:     prdata = CFG_DW'(r_row_up);
            REG_REF_TEMP:   prdata = CFG_DW'(unsigned'(r_ref_temp));
            REG_ACC_SLOPE:  prdata = CFG_DW'(unsigned'(r_acc_slope));
            REG_GYR_SLOPE:  prdata = CFG_DW'(unsigned'(r_gyr_slope));
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_vin;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_vin[0] = i_valid;
        for (int k = 1; k < NSTG; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // ---------------- stage 1: bias and temperature differences ----------------
    logic signed [FIELD_W-1:0] w_raw  [CHANNELS];
    logic signed [DW-1:0]      n_diff [CHANNELS];
    logic signed [DW-1:0]      n_dt;
    logic signed [DW-1:0]      r_s1_diff [CHANNELS];
    logic signed [DW-1:0]      r_s1_dt;

    assign w_raw[0] = i_accel_x_raw;
    assign w_raw[1] = i_accel_y_raw;
    assign w_raw[2] = i_accel_z_raw;
    assign w_raw[3] = i_gyro_x_raw;
    assign w_raw[4] = i_gyro_y_raw;
    assign w_raw[5] = i_gyro_z_raw;

    always_comb begin
        n_dt = DW'(i_temperature_raw) - DW'(r_ref_temp);
        for (int c = 0; c < AXES; c++) begin
            n_diff[c]      = DW'(w_raw[c]) - DW'(f_lane(r_acc_offset, 2'(c)));
            n_diff[AXES+c] = DW'(w_raw[AXES+c]) - DW'(f_lane(r_gyr_offset, 2'(c)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && w_vin[0]) begin
            r_s1_diff <= n_diff;
            r_s1_dt   <= n_dt;
        end
    end

    // ---------------- stage 2: slope times dT ----------------
    logic signed [DW-1:0] r_s2_diff [CHANNELS];
    logic signed [TW-1:0] r_s2_term [SENSORS];

    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && w_vin[1]) begin
            r_s2_diff    <= r_s1_diff;
            r_s2_term[0] <= TW'(r_acc_slope) * TW'(r_s1_dt);
            r_s2_term[1] <= TW'(r_gyr_slope) * TW'(r_s1_dt);
        end
    end

    // ---------------- stage 3: corrected component, clamped ----------------
    logic signed [PW-1:0] n_pre  [CHANNELS];
    logic signed [CW-1:0] n_corr [CHANNELS];
    logic signed [CW-1:0] r_s3_corr [CHANNELS];

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_pre[i] = (PW'(r_s2_diff[i]) <<< SLOPE_FRAC_BITS) - PW'(r_s2_term[i / AXES]);
            if (n_pre[i] > CORR_HI) begin
                n_corr[i] = CORR_HI[CW-1:0];
            end else if (n_pre[i] < CORR_LO) begin
                n_corr[i] = CORR_LO[CW-1:0];
            end else begin
                n_corr[i] = n_pre[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && w_vin[2]) begin
            r_s3_corr <= n_corr;
        end
    end

    // ---------------- stage 4: matrix products ----------------
    // index: sensor*9 + row*3 + column
    logic [PACKED_W-1:0]   w_row [AXES];
    logic signed [PRW-1:0] n_prod [SENSORS*AXES*AXES];
    logic signed [PRW-1:0] r_s4_prod [SENSORS*AXES*AXES];

    assign w_row[0] = r_row_fwd;
    assign w_row[1] = r_row_left;
    assign w_row[2] = r_row_up;

    always_comb begin
        for (int s = 0; s < SENSORS; s++) begin
            for (int r = 0; r < AXES; r++) begin
                for (int c = 0; c < AXES; c++) begin
                    n_prod[s*AXES*AXES + r*AXES + c] =
                        PRW'(f_lane(w_row[r], 2'(c))) * PRW'(r_s3_corr[s*AXES + c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3] && w_vin[3]) begin
            r_s4_prod <= n_prod;
        end
    end

    // ---------------- stage 5: row sums ----------------
    logic signed [SW-1:0] n_sum [CHANNELS];
    logic signed [SW-1:0] r_s5_sum [CHANNELS];

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_sum[i] = SW'(r_s4_prod[i*AXES])
                     + SW'(r_s4_prod[i*AXES + 1])
                     + SW'(r_s4_prod[i*AXES + 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4] && w_vin[4]) begin
            r_s5_sum <= n_sum;
        end
    end

    // ---------------- stage 6: truncate toward zero, saturate ----------------
    logic [SW-1:0]             n_mag [CHANNELS];
    logic [SW-1:0]             n_shr [CHANNELS];
    logic signed [FIELD_W-1:0] n_out [CHANNELS];
    logic signed [FIELD_W-1:0] r_s6_out [CHANNELS];

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_mag[i] = r_s5_sum[i][SW-1] ? SW'(-r_s5_sum[i]) : SW'(r_s5_sum[i]);
            n_shr[i] = n_mag[i] >> SH;
            if (r_s5_sum[i][SW-1]) begin
                if (n_shr[i] >= SW'(32'd32768)) begin
                    n_out[i] = 16'sh8000;
                end else begin
                    n_out[i] = -$signed(n_shr[i][FIELD_W-1:0]);
                end
            end else begin
                if (n_shr[i] > SW'(32'd32767)) begin
                    n_out[i] = 16'sh7FFF;
                end else begin
                    n_out[i] = $signed(n_shr[i][FIELD_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5] && w_vin[5]) begin
            r_s6_out <= n_out;
        end
    end

    assign o_accel_forward = r_s6_out[0];
    assign o_accel_left    = r_s6_out[1];
    assign o_accel_up      = r_s6_out[2];
    assign o_rate_roll     = r_s6_out[3];
    assign o_rate_pitch    = r_s6_out[4];
    assign o_rate_yaw      = r_s6_out[5];

`ifndef SYNTHESIS
    // an accepted beat always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat did not enter stage 1");

    // input stall is raised only when the first stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0])
        else $error("input stalled with an empty first stage");

    // a blocked middle stage keeps its beat
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !w_rdy[4]) |=> r_vld[3])
        else $error("stage 4 beat lost under stall");

    // the output only becomes valid from a full sum stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[4]))
        else $error("output valid without a beat in the sum stage");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for imu_bias_temp_rotate_unit
// Programs the register file over APB, streams raw IMU samples through the
// valid/stall channels with random gaps and stalls, and compares every
// corrected frame against a fixed-point predictor held in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import imubtr_pkg::*;

    localparam int MAT_FB      = 14;
    localparam int SLOPE_FB    = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;

    typedef logic signed [FIELD_W-1:0] t_axis;

    typedef struct {
        t_axis accel_x, accel_y, accel_z;
        t_axis gyro_x, gyro_y, gyro_z;
        t_axis temperature;
    } t_imu_sample;

    typedef struct {
        t_axis accel_forward, accel_left, accel_up;
        t_axis rate_roll, rate_pitch, rate_yaw;
    } t_imu_frame;

    // Predicts corrected frames from accepted samples and checks the output
    class frame_checker;
        logic [47:0]        acc_offset, gyr_offset;
        logic [47:0]        rows[3];
        logic signed [15:0] ref_temp;
        logic signed [31:0] accel_slope, gyro_slope;
        t_imu_frame         expected_frames[$];
        int                 errors;

        function new();
            acc_offset  = '0;
            gyr_offset  = '0;
            rows[0]     = 48'h0000_0000_4000;
            rows[1]     = 48'h0000_4000_0000;
            rows[2]     = 48'h4000_0000_0000;
            ref_temp    = '0;
            accel_slope = '0;
            gyro_slope  = '0;
            errors      = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] value);
            case (idx)
                REG_ACC_OFFSET: acc_offset  = value[47:0];
                REG_GYR_OFFSET: gyr_offset  = value[47:0];
                REG_ROW_FWD:    rows[0]     = value[47:0];
                REG_ROW_LEFT:   rows[1]     = value[47:0];
                REG_ROW_UP:     rows[2]     = value[47:0];
                REG_REF_TEMP:   ref_temp    = value[15:0];
                REG_ACC_SLOPE:  accel_slope = value[31:0];
                REG_GYR_SLOPE:  gyro_slope  = value[31:0];
                default: ;
            endcase
        endfunction

        function t_axis lane_of(logic [47:0] packed_v, int k);
            return packed_v[16*k +: 16];
        endfunction

        // bias and temperature removed, kept in Q.SLOPE_FB, clamped to +/-2^20
        function longint correct_axis(t_axis raw, t_axis bias, longint term);
            longint lim, v;
            lim = longint'(1) <<< (20 + SLOPE_FB);
            v = (longint'(raw) - longint'(bias)) * (longint'(1) <<< SLOPE_FB) - term;
            if (v < -lim)
                v = -lim;
            if (v > lim - 1)
                v = lim - 1;
            return v;
        endfunction

        // row times vector, truncated toward zero, saturated to int16
        function t_axis rotate_row(logic [47:0] row, longint c0, longint c1, longint c2);
            longint s, mag, q;
            s = longint'(lane_of(row, 0)) * c0 + longint'(lane_of(row, 1)) * c1
                + longint'(lane_of(row, 2)) * c2;
            mag = (s < 0) ? -s : s;
            mag = mag >>> (SLOPE_FB + MAT_FB);
            if (mag > 40000)
                mag = 40000;
            q = (s < 0) ? -mag : mag;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[15:0];
        endfunction

        function t_imu_frame predict_frame(t_imu_sample s);
            t_imu_frame f;
            longint     dt, aterm, gterm;
            longint     a0, a1, a2, g0, g1, g2;
            dt    = longint'(s.temperature) - longint'(ref_temp);
            aterm = longint'(accel_slope) * dt;
            gterm = longint'(gyro_slope) * dt;
            a0 = correct_axis(s.accel_x, lane_of(acc_offset, 0), aterm);
            a1 = correct_axis(s.accel_y, lane_of(acc_offset, 1), aterm);
            a2 = correct_axis(s.accel_z, lane_of(acc_offset, 2), aterm);
            g0 = correct_axis(s.gyro_x, lane_of(gyr_offset, 0), gterm);
            g1 = correct_axis(s.gyro_y, lane_of(gyr_offset, 1), gterm);
            g2 = correct_axis(s.gyro_z, lane_of(gyr_offset, 2), gterm);
            f.accel_forward = rotate_row(rows[0], a0, a1, a2);
            f.accel_left    = rotate_row(rows[1], a0, a1, a2);
            f.accel_up      = rotate_row(rows[2], a0, a1, a2);
            f.rate_roll     = rotate_row(rows[0], g0, g1, g2);
            f.rate_pitch    = rotate_row(rows[1], g0, g1, g2);
            f.rate_yaw      = rotate_row(rows[2], g0, g1, g2);
            return f;
        endfunction

        function void note_sample(t_imu_sample s);
            expected_frames.push_back(predict_frame(s));
        endfunction

        function void compare_axis(string name, t_axis want, t_axis got);
            if (got !== want) begin
                $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_frame(t_imu_frame got);
            t_imu_frame want;
            if (expected_frames.size() == 0) begin
                $display("%0t ns: output beat with no sample pending", $time);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            compare_axis("accel_forward", want.accel_forward, got.accel_forward);
            compare_axis("accel_left", want.accel_left, got.accel_left);
            compare_axis("accel_up", want.accel_up, got.accel_up);
            compare_axis("rate_roll", want.rate_roll, got.rate_roll);
            compare_axis("rate_pitch", want.rate_pitch, got.rate_pitch);
            compare_axis("rate_yaw", want.rate_yaw, got.rate_yaw);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    t_axis               i_accel_x_raw = '0, i_accel_y_raw = '0, i_accel_z_raw = '0;
    t_axis               i_gyro_x_raw = '0, i_gyro_y_raw = '0, i_gyro_z_raw = '0;
    t_axis               i_temperature_raw = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [CFG_AW-1:0]   paddr   = '0;
    logic [CFG_DW-1:0]   pwdata  = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    logic                o_stall, o_valid;
    t_axis               o_accel_forward, o_accel_left, o_accel_up;
    t_axis               o_rate_roll, o_rate_pitch, o_rate_yaw;

    logic                tx_idle = 1'b0;
    logic                rx_idle = 1'b0;
    logic                rx_hold = 1'b0;
    int                  samples_sent = 0;
    int                  cycle_count  = 0;
    frame_checker        frames = new();

    imu_bias_temp_rotate_unit #(
        .MATRIX_FRAC_BITS (MAT_FB),
        .SLOPE_FRAC_BITS  (SLOPE_FB)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_accel_x_raw     (i_accel_x_raw),
        .i_accel_y_raw     (i_accel_y_raw),
        .i_accel_z_raw     (i_accel_z_raw),
        .i_gyro_x_raw      (i_gyro_x_raw),
        .i_gyro_y_raw      (i_gyro_y_raw),
        .i_gyro_z_raw      (i_gyro_z_raw),
        .i_temperature_raw (i_temperature_raw),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_accel_forward   (o_accel_forward),
        .o_accel_left      (o_accel_left),
        .o_accel_up        (o_accel_up),
        .o_rate_roll       (o_rate_roll),
        .o_rate_pitch      (o_rate_pitch),
        .o_rate_yaw        (o_rate_yaw),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin : reset_gen
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: one random stall run per beat while rx_idle is set, plus the long hold-off
    initial begin : frame_sink
        int         wait_left;
        t_imu_frame got;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.accel_forward = o_accel_forward;
                got.accel_left    = o_accel_left;
                got.accel_up      = o_accel_up;
                got.rate_roll     = o_rate_roll;
                got.rate_pitch    = o_rate_pitch;
                got.rate_yaw      = o_rate_yaw;
                frames.check_frame(got);
                wait_left = rx_idle ? int'($urandom_range(0, 16)) : 0;
            end
            if (wait_left > 0) begin
                i_stall <= 1'b1;
                wait_left--;
            end else begin
                i_stall <= rx_hold;
            end
        end
    end

    // sink stops for a long stretch while the source keeps offering beats
    initial begin : sink_hold_off
        wait (samples_sent == 600);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic t_imu_sample mk(t_axis ax, t_axis ay, t_axis az, t_axis gx,
                                       t_axis gy, t_axis gz, t_axis t);
        t_imu_sample s;
        s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
        s.gyro_x  = gx; s.gyro_y  = gy; s.gyro_z  = gz;
        s.temperature = t;
        return s;
    endfunction

    // mostly uniform, with a bias toward the rails and zero
    function automatic t_axis pick_axis();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return r[15:0];
        endcase
    endfunction

    function automatic t_imu_sample random_sample();
        return mk(pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                  pick_axis(), pick_axis());
    endfunction

    // bits above the register width carry junk, which must be ignored
    task automatic apb_write(input t_reg_idx idx, input logic [63:0] value);
        logic [63:0] bus;
        bus = {$urandom, $urandom};
        case (idx)
            REG_REF_TEMP:                 bus[15:0] = value[15:0];
            REG_ACC_SLOPE, REG_GYR_SLOPE: bus[31:0] = value[31:0];
            default:                      bus[47:0] = value[47:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= bus;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.write_reg(idx, bus);
        @(posedge i_clk);
    endtask

    task automatic program_all(input logic [47:0] abias, input logic [47:0] gbias,
                               input logic [47:0] r0, input logic [47:0] r1,
                               input logic [47:0] r2, input logic [15:0] tref,
                               input logic [31:0] aslope, input logic [31:0] gslope);
        apb_write(REG_ACC_OFFSET, 64'(abias));
        apb_write(REG_GYR_OFFSET, 64'(gbias));
        apb_write(REG_ROW_FWD, 64'(r0));
        apb_write(REG_ROW_LEFT, 64'(r1));
        apb_write(REG_ROW_UP, 64'(r2));
        apb_write(REG_REF_TEMP, 64'(tref));
        apb_write(REG_ACC_SLOPE, 64'(aslope));
        apb_write(REG_GYR_SLOPE, 64'(gslope));
    endtask

    task automatic send_sample(input t_imu_sample s);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 16)) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_accel_x_raw     <= s.accel_x;
        i_accel_y_raw     <= s.accel_y;
        i_accel_z_raw     <= s.accel_z;
        i_gyro_x_raw      <= s.gyro_x;
        i_gyro_y_raw      <= s.gyro_y;
        i_gyro_z_raw      <= s.gyro_z;
        i_temperature_raw <= s.temperature;
        do @(posedge i_clk); while (o_stall);
        frames.note_sample(s);
        samples_sent++;
    endtask

    // pipeline is six deep; waits until no frame is pending, then idles before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        while (frames.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    task automatic program_random(input bit wild);
        int a, g;
        if (wild) begin
            program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                        $urandom, $urandom);
        end else begin
            // plausible calibration: small biases, entries within +/-1.0, mild slopes
            a = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            g = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            program_all(pack3(near(2000), near(2000), near(2000)),
                        pack3(near(500), near(500), near(500)),
                        pack3(near(16384), near(16384), near(16384)),
                        pack3(near(16384), near(16384), near(16384)),
                        pack3(near(16384), near(16384), near(16384)),
                        $urandom, a, g);
        end
    endtask

    initial begin : stimulus
        wait (i_rst_n);
        @(posedge i_clk);

        // reset settings: identity rotation, nothing subtracted
        send_sample(mk(0, 0, 0, 0, 0, 0, 0));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(mk(-32768, 32767, -1, 32767, -32768, 1, -32768));
        send_sample(mk(-1, -1, -1, -1, -1, -1, 32767));
        drain();

        // rails everywhere: -2.0 entries, extreme biases, slopes that hit the clamp
        program_all(pack3(16'h8000, 16'h7FFF, 16'h0001),
                    pack3(16'h7FFF, 16'h8000, 16'hFFFF),
                    pack3(16'h8000, 16'h8000, 16'h8000),
                    pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    pack3(16'h4000, 16'h0000, 16'hC000),
                    16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(mk(32767, -32768, 0, -32768, 32767, 0, 32767));
        send_sample(mk(-32768, 32767, 0, 32767, -32768, 0, -32768));
        send_sample(mk(0, 0, 0, 0, 0, 0, -32767));
        send_sample(mk(1, -1, 1, -1, 1, -1, -32760));
        send_sample(mk(12345, -12345, 32767, -32768, 100, -100, 0));
        drain();

        // half-count slopes give fractions, so truncation toward zero shows
        program_all(pack3(16'h0000, 16'h0000, 16'h0000),
                    pack3(16'h0001, 16'hFFFF, 16'h0000),
                    pack3(16'h4000, 16'h0000, 16'h0000),
                    pack3(16'h0000, 16'hC000, 16'h0000),
                    pack3(16'h2000, 16'h2000, 16'h8000),
                    16'h7FFF, 32'h0000_8000, 32'hFFFF_8000);
        send_sample(mk(0, 0, 0, 0, 0, 0, 32766));
        send_sample(mk(0, 0, 0, 0, 0, 0, 32764));
        send_sample(mk(3, -3, 5, -5, 7, -7, 32767));
        send_sample(mk(-32768, -32768, 32767, 32767, -32768, 32767, -32768));
        send_sample(mk(1, 1, 1, 1, 1, 1, 32001));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 3)
                0: begin
                    tx_idle <= 1'b1;
                    rx_idle <= 1'b1;
                end
                1: begin
                    tx_idle <= 1'b0;
                    rx_idle <= 1'b0;
                end
                default: begin
                    tx_idle <= 1'($urandom_range(0, 1));
                    rx_idle <= 1'($urandom_range(0, 1));
                end
            endcase
            program_random(p % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample());
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (frames.errors == 0 && frames.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
